@@ rtl/core/ecn_pkg.sv @@
package ecn_pkg;

   localparam logic [2:0] MODE_SAMPLE        = 3'd0;
   localparam logic [2:0] MODE_START_CALIB   = 3'd1;
   localparam logic [2:0] MODE_CANCEL_CALIB  = 3'd2;
   localparam logic [2:0] MODE_START_CAPTURE = 3'd3;
   localparam logic [2:0] MODE_STOP_CAPTURE  = 3'd4;

   localparam logic [1:0] REG_REST_PHASE     = 2'd0;
   localparam logic [1:0] REG_CONTRACT_PHASE = 2'd1;
   localparam logic [1:0] REG_MIN_RANGE      = 2'd2;

   localparam int unsigned MODE_BITS = 3;
   localparam int unsigned TIME_BITS = 32;
   localparam int unsigned DUR_BITS  = 16;
   localparam int unsigned PCT_SCALE = 100;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DECIDE = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_PMUL  = 6'b001000,
      ST_FINAL = 6'b010000,
      ST_OUT   = 6'b100000
   } back_state_type;

endpackage

@@ rtl/core/emg_calibrate_normalize_core.sv @@
// Each transaction passes ST_IDLE, ST_DECIDE and ST_OUT; a sample that completes
// calibration also passes ST_FINAL, and a baseline or percentage runs the 36-step
// shift-subtract divider. The back end takes no new transaction until its last
// result is accepted; a two-entry queue in front accepts up to two more meanwhile.
// Reset is synchronous and active high; it clears the control state and restores
// the register defaults.
module emg_calibrate_normalize_core import ecn_pkg::*; #(
   parameter int unsigned SAMPLE_BITS = 12,
   parameter int unsigned COUNT_BITS = 16,
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[2:0], raw_sample, now_ms[31:0], zero fill
   input  logic [((MODE_BITS+SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // value
   output logic [((SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   // value_valid, is_percent, calibrated_now, calibrating_now, phase_now,
   // start_refused, calib_finished, calib_failed
   output logic [7:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int unsigned QW = MODE_BITS + SAMPLE_BITS + TIME_BITS;
   localparam int unsigned OW = ((SAMPLE_BITS + 7) / 8) * 8;

   logic [DUR_BITS-1:0]    rest_ff, contract_ff;
   logic [SAMPLE_BITS-1:0] minr_ff;
   logic                   q_valid, q_ready;
   logic [QW-1:0]          q_item;
   logic [SAMPLE_BITS-1:0] value;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff <= 16'd10000;
         contract_ff <= 16'd5000;
         minr_ff <= SAMPLE_BITS'(100);
      end else if (csr_we) begin
         case (csr_index)
            REG_REST_PHASE:     rest_ff <= csr_wdata;
            REG_CONTRACT_PHASE: contract_ff <= csr_wdata;
            REG_MIN_RANGE:      minr_ff <= SAMPLE_BITS'(csr_wdata[11:0]);
            default: ;
         endcase
      end
   end

   ecn_front #(.QW(QW)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(req_tdata[QW-1:0]),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
   );

   ecn_back #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS),
              .FRAC_BITS(FRAC_BITS), .QW(QW)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
      .rest_ms(rest_ff), .contract_ms(contract_ff), .min_range(minr_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_value(value), .out_flags(rsp_tuser)
   );

   assign rsp_tdata = OW'(value);
endmodule

@@ rtl/core/ecn_front.sv @@
module ecn_front import ecn_pkg::*; #(
   parameter int unsigned QW = 47
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [QW-1:0] in_item,
   output logic          q_valid,
   input  logic          q_ready,
   output logic [QW-1:0] q_item
);
   logic [QW-1:0] slot_ff [2];
   logic [QW-1:0] slot_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = slot_ff[0];
   assign push = in_valid && in_ready;
   assign pop  = q_valid && q_ready;

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      cnt_in = cnt_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         slot_in[cnt_in[0]] = in_item;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end
endmodule

@@ rtl/core/ecn_divider.sv @@
module ecn_divider #(
   parameter int unsigned NW = 36,
   parameter int unsigned DW = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] numer,
   input  logic [DW-1:0] denom,
   output logic          done,
   output logic [NW-1:0] quot
);
   localparam int unsigned CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff;
   logic [CW-1:0] n_ff;
   logic          busy_ff;
   logic [DW:0]   trial;

   assign quot = q_ff;
   assign done = busy_ff && (n_ff == CW'(0));

   always_comb begin
      trial = {r_ff[DW-1:0], q_ff[NW-1]};
      q_in = {q_ff[NW-2:0], 1'b0};
      r_in = trial;
      if (trial >= {1'b0, d_ff}) begin
         r_in = trial - {1'b0, d_ff};
         q_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         q_ff <= numer;
         r_ff <= '0;
         d_ff <= denom;
         n_ff <= CW'(NW);
      end else if (busy_ff) begin
         if (n_ff == CW'(0)) begin
            busy_ff <= 1'b0;
         end else begin
            q_ff <= q_in;
            r_ff <= r_in;
            n_ff <= n_ff - CW'(1);
         end
      end
   end
endmodule

@@ rtl/core/ecn_back.sv @@
module ecn_back import ecn_pkg::*; #(
   parameter int unsigned SAMPLE_BITS = 12,
   parameter int unsigned COUNT_BITS = 16,
   parameter int unsigned FRAC_BITS = 8,
   parameter int unsigned QW = 47
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  logic [QW-1:0]          q_item,
   input  logic [DUR_BITS-1:0]    rest_ms,
   input  logic [DUR_BITS-1:0]    contract_ms,
   input  logic [SAMPLE_BITS-1:0] min_range,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [SAMPLE_BITS-1:0] out_value,
   output logic [7:0]             out_flags
);
   localparam int unsigned SUMW = SAMPLE_BITS + COUNT_BITS;
   localparam int unsigned BQW  = SAMPLE_BITS + FRAC_BITS;
   localparam int unsigned NW   = SUMW + FRAC_BITS;
   localparam int unsigned DW   = (COUNT_BITS > BQW + 1) ? COUNT_BITS : BQW + 1;
   localparam int unsigned PW   = BQW + 7;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   back_state_type st_ff;
   logic cap_ff, calg_ff, cald_ff, ph_ff;
   logic [TIME_BITS-1:0]   pst_ff;
   logic [SUMW-1:0]        sum_ff;
   logic [COUNT_BITS-1:0]  cnt_ff;
   logic [SAMPLE_BITS-1:0] rmax_ff, peak_ff;
   logic [BQW-1:0]         base_ff;
   logic [MODE_BITS-1:0]   mode_ff;
   logic [SAMPLE_BITS-1:0] raw_ff;
   logic [TIME_BITS-1:0]   now_ff;
   logic [SAMPLE_BITS-1:0] val_ff;
   logic vld_ff, pct_ff, ref_ff, fin_ff, fail_ff, div_base_ff;
   logic [PW-1:0]          pnum_ff;
   logic [BQW:0]           pden_ff;

   logic                   dstart, ddone;
   logic [NW-1:0]          dnum, dquot;
   logic [DW-1:0]          dden;

   logic [SUMW-1:0]        sum_acc;
   logic [COUNT_BITS-1:0]  cnt_acc;
   logic [SAMPLE_BITS-1:0] rmax_acc;
   logic [TIME_BITS-1:0]   elapsed;
   logic [BQW:0]           rq, pq;
   logic [BQW+1:0]         thr;

   logic [SAMPLE_BITS-1:0] dec_val;
   logic                   dec_vld, dec_pct, dec_ref, dec_fin, dec_base, dec_div;
   back_state_type         dec_st;

   ecn_divider #(.NW(NW), .DW(DW)) u_div (
      .clock(clock), .reset(reset), .start(dstart),
      .numer(dnum), .denom(dden), .done(ddone), .quot(dquot)
   );

   assign q_ready   = (st_ff == ST_IDLE) && !out_valid;
   assign out_valid = (st_ff == ST_OUT);
   assign out_value = val_ff;
   assign out_flags = {fail_ff, fin_ff, ref_ff, ph_ff, calg_ff, cald_ff, pct_ff, vld_ff};

   always_comb begin
      sum_acc = sum_ff;
      cnt_acc = cnt_ff;
      if (cnt_ff != CMAX) begin
         sum_acc = sum_ff + SUMW'(raw_ff);
         cnt_acc = cnt_ff + COUNT_BITS'(1);
      end
      rmax_acc = (raw_ff > rmax_ff) ? raw_ff : rmax_ff;
      elapsed = now_ff - pst_ff;
      rq  = {1'b0, raw_ff, {FRAC_BITS{1'b0}}};
      pq  = {1'b0, peak_ff, {FRAC_BITS{1'b0}}};
      thr = (BQW+2)'(base_ff) + (BQW+2)'({min_range, {FRAC_BITS{1'b0}}});
      dstart = 1'b0;
      dnum = '0;
      dden = '0;
      if (st_ff == ST_DECIDE && div_base_ff) begin
         dstart = 1'b1;
         dnum = {sum_ff, {FRAC_BITS{1'b0}}};
         dden = DW'(cnt_ff);
      end else if (st_ff == ST_PMUL) begin
         dstart = 1'b1;
         dnum = NW'(pnum_ff);
         dden = DW'(pden_ff);
      end
   end

   always_comb begin
      dec_val  = '0;
      dec_vld  = 1'b0;
      dec_pct  = 1'b0;
      dec_ref  = 1'b0;
      dec_fin  = 1'b0;
      dec_base = 1'b0;
      dec_div  = 1'b0;
      case (mode_ff)
         MODE_SAMPLE: begin
            if (calg_ff) begin
               if (!div_base_ff && cnt_acc != '0) begin
                  if (!ph_ff && elapsed >= TIME_BITS'(rest_ms)) begin
                     dec_base = 1'b1;
                  end else if (ph_ff && elapsed >= TIME_BITS'(contract_ms)) begin
                     dec_fin = 1'b1;
                  end
               end
            end else if (cap_ff) begin
               dec_vld = 1'b1;
               if (cald_ff) begin
                  dec_pct = 1'b1;
                  if (rq <= {1'b0, base_ff}) begin
                     dec_val = '0;
                  end else if (raw_ff >= peak_ff || pq <= {1'b0, base_ff}) begin
                     dec_val = SAMPLE_BITS'(PCT_SCALE);
                  end else begin
                     dec_div = 1'b1;
                  end
               end else begin
                  dec_val = raw_ff;
               end
            end
         end
         MODE_START_CALIB: dec_ref = cap_ff || calg_ff;
         default: ;
      endcase
      if (div_base_ff) begin
         dec_st = ST_DIV;
      end else if (dec_base) begin
         dec_st = ST_DECIDE;
      end else if (dec_fin) begin
         dec_st = ST_FINAL;
      end else if (dec_div) begin
         dec_st = ST_PMUL;
      end else begin
         dec_st = ST_OUT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         cap_ff <= 1'b0; calg_ff <= 1'b0; cald_ff <= 1'b0; ph_ff <= 1'b0;
         pst_ff <= '0; sum_ff <= '0; cnt_ff <= '0; rmax_ff <= '0;
         base_ff <= '0; peak_ff <= '1;
         div_base_ff <= 1'b0;
      end else begin
         case (st_ff)
            ST_IDLE: begin
               if (q_valid && q_ready) begin
                  mode_ff <= q_item[MODE_BITS-1:0];
                  raw_ff  <= q_item[MODE_BITS +: SAMPLE_BITS];
                  now_ff  <= q_item[MODE_BITS+SAMPLE_BITS +: TIME_BITS];
                  st_ff   <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               val_ff <= dec_val; vld_ff <= dec_vld; pct_ff <= dec_pct;
               ref_ff <= dec_ref; fin_ff <= dec_fin; fail_ff <= 1'b0;
               div_base_ff <= dec_base;
               st_ff <= dec_st;
               case (mode_ff)
                  MODE_SAMPLE: begin
                     if (calg_ff && !div_base_ff) begin
                        sum_ff <= sum_acc; cnt_ff <= cnt_acc; rmax_ff <= rmax_acc;
                        if (dec_base) begin
                           ph_ff <= 1'b1;
                           pst_ff <= now_ff;
                        end else if (dec_fin) begin
                           peak_ff <= rmax_acc;
                           calg_ff <= 1'b0;
                        end
                     end else if (dec_div) begin
                        pnum_ff <= PW'(rq - {1'b0, base_ff}) * PW'(PCT_SCALE);
                        pden_ff <= pq - {1'b0, base_ff};
                     end
                  end
                  MODE_START_CALIB: begin
                     if (!dec_ref) begin
                        calg_ff <= 1'b1; ph_ff <= 1'b0; pst_ff <= now_ff;
                        sum_ff <= '0; cnt_ff <= '0; rmax_ff <= '0; cald_ff <= 1'b0;
                     end
                  end
                  MODE_CANCEL_CALIB: begin
                     if (calg_ff) begin
                        calg_ff <= 1'b0; ph_ff <= 1'b0;
                        sum_ff <= '0; cnt_ff <= '0; rmax_ff <= '0;
                     end
                  end
                  MODE_START_CAPTURE: cap_ff <= 1'b1;
                  MODE_STOP_CAPTURE:  cap_ff <= 1'b0;
                  default: ;
               endcase
            end
            ST_DIV: begin
               if (ddone) begin
                  if (pct_ff) begin
                     val_ff <= SAMPLE_BITS'(dquot);
                  end else begin
                     base_ff <= BQW'(dquot);
                     sum_ff <= '0; cnt_ff <= '0; rmax_ff <= '0;
                  end
                  st_ff <= ST_OUT;
               end
            end
            ST_PMUL: st_ff <= ST_DIV;
            ST_FINAL: begin
               cald_ff <= ((BQW+2)'(pq) > thr);
               fail_ff <= !((BQW+2)'(pq) > thr);
               sum_ff <= '0; cnt_ff <= '0; rmax_ff <= '0;
               st_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_ready) st_ff <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

@@ bench/ecn_checker.sv @@
module ecn_checker import ecn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic [7:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          errors,
   output int          pending
);

   typedef struct packed {
      logic [11:0] value;
      logic [7:0]  flags;
   } emg_result_type;

   emg_result_type expected_q[$];

   logic [15:0] rest_ms, contract_ms;
   logic [11:0] margin;
   logic        capturing, calibrating, calibrated, phase;
   logic [31:0] phase_start;
   logic [27:0] sum;
   logic [15:0] count;
   logic [11:0] running_max, peak;
   logic [19:0] baseline;

   assign pending = expected_q.size();

   function automatic logic [11:0] percent_of(logic [11:0] raw);
      logic [63:0] rq, pq;
      rq = 64'({raw, 8'd0});
      pq = 64'({peak, 8'd0});
      if (rq <= 64'(baseline)) return 12'd0;
      if (raw >= peak || pq <= 64'(baseline)) return 12'd100;
      return 12'(((rq - 64'(baseline)) * 64'd100) / (pq - 64'(baseline)));
   endfunction

   task automatic predict_event(logic [47:0] d);
      logic [2:0]  mode;
      logic [11:0] raw;
      logic [31:0] now, elapsed;
      logic [11:0] value;
      logic        valid, pct, refused, finished, failed;
      emg_result_type res;
      mode = d[2:0];
      raw = d[14:3];
      now = d[46:15];
      value = '0;
      {valid, pct, refused, finished, failed} = '0;
      case (mode)
         MODE_SAMPLE: begin
            if (calibrating) begin
               if (count != 16'hFFFF) begin
                  sum = sum + 28'(raw);
                  count = count + 16'd1;
               end
               if (raw > running_max) running_max = raw;
               if (count != 16'd0) begin
                  elapsed = now - phase_start;
                  if (!phase && elapsed >= 32'(rest_ms)) begin
                     baseline = 20'(({36'd0, sum} << 8) / 64'(count));
                     phase = 1'b1;
                     phase_start = now;
                     sum = '0; count = '0; running_max = '0;
                  end else if (phase && elapsed >= 32'(contract_ms)) begin
                     peak = running_max;
                     calibrated = {1'b0, peak, 8'd0} > 21'(baseline) + {1'b0, margin, 8'd0};
                     finished = 1'b1;
                     failed = !calibrated;
                     calibrating = 1'b0;
                     sum = '0; count = '0; running_max = '0;
                  end
               end
            end else if (capturing) begin
               valid = 1'b1;
               if (calibrated) begin
                  pct = 1'b1;
                  value = percent_of(raw);
               end else value = raw;
            end
         end
         MODE_START_CALIB: begin
            if (capturing || calibrating) refused = 1'b1;
            else begin
               calibrating = 1'b1; phase = 1'b0; phase_start = now;
               sum = '0; count = '0; running_max = '0; calibrated = 1'b0;
            end
         end
         MODE_CANCEL_CALIB: begin
            if (calibrating) begin
               calibrating = 1'b0; phase = 1'b0;
               sum = '0; count = '0; running_max = '0;
            end
         end
         MODE_START_CAPTURE: capturing = 1'b1;
         MODE_STOP_CAPTURE: capturing = 1'b0;
         default: ;
      endcase
      res = {value, failed, finished, refused, phase, calibrating, calibrated, pct, valid};
      expected_q.insert(expected_q.size(), res);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rest_ms = 16'd10000; contract_ms = 16'd5000; margin = 12'd100;
         capturing = 1'b0; calibrating = 1'b0; calibrated = 1'b0; phase = 1'b0;
         phase_start = '0; sum = '0; count = '0; running_max = '0;
         baseline = '0; peak = 12'hFFF;
         errors <= 0;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_REST_PHASE: rest_ms = csr_wdata;
               REG_CONTRACT_PHASE: contract_ms = csr_wdata;
               REG_MIN_RANGE: margin = csr_wdata[11:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_event(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               if (errors < 10) $display("unexpected result %h/%h", rsp_tdata, rsp_tuser);
               errors <= errors + 1;
            end else begin
               emg_result_type e;
               e = expected_q.pop_front();
               if (e.value !== rsp_tdata[11:0] || e.flags !== rsp_tuser) begin
                  if (errors < 10)
                     $display("mismatch: expected value %0d flags %b, got %0d flags %b",
                              e.value, e.flags, rsp_tdata[11:0], rsp_tuser);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

endmodule

@@ bench/tb.sv @@
module tb;
   import ecn_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0, req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid, rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic [7:0]  rsp_tuser;
   logic        csr_we = 0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   int          errors, pending;
   int          send_idle_pct = 0, recv_idle_pct = 0;
   int          stall_cycles = 0;
   logic [31:0] clock_ms = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   emg_calibrate_normalize_core uut (.*);

   ecn_checker checker_i (.*);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 5000) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   task automatic send_event(logic [2:0] mode, logic [11:0] raw, logic [31:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, now, raw, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
   endtask

   // A calibration run: start, rest samples, contraction samples, with time advancing.
   task automatic calibration_run(int rest_n, int con_n, int step, logic [11:0] lo,
                                  logic [11:0] hi);
      send_event(MODE_START_CALIB, 12'($urandom), clock_ms);
      repeat (rest_n) begin
         clock_ms += $urandom_range(step);
         send_event(MODE_SAMPLE, 12'($urandom_range(hi, lo)), clock_ms);
      end
      repeat (con_n) begin
         clock_ms += $urandom_range(step);
         send_event(MODE_SAMPLE, 12'($urandom_range(4095, lo)), clock_ms);
      end
   endtask

   task automatic random_phase(int n);
      int k;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(9))
            0, 1: calibration_run($urandom_range(12, 1), $urandom_range(12, 1), 30,
                                  12'($urandom_range(400)), 12'($urandom_range(4095, 400)));
            2: send_event(3'($urandom), 12'($urandom), $urandom);
            3: send_event(MODE_START_CAPTURE, 12'($urandom), clock_ms);
            4: send_event(MODE_STOP_CAPTURE, 12'($urandom), clock_ms);
            5: send_event(MODE_CANCEL_CALIB, 12'($urandom), clock_ms);
            default: begin
               clock_ms += $urandom_range(20);
               send_event(MODE_SAMPLE, 12'($urandom), clock_ms);
            end
         endcase
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 0;
      write_reg(REG_REST_PHASE, 16'd40);
      write_reg(REG_CONTRACT_PHASE, 16'd30);
      write_reg(REG_MIN_RANGE, 16'd100);

      send_event(MODE_SAMPLE, 12'hFFF, 32'hFFFF_FFFF);
      send_event(MODE_CANCEL_CALIB, 12'd0, 32'd0);
      send_event(3'd5, 12'd1, 32'd0);
      send_event(3'd7, 12'd2, 32'd0);
      send_event(MODE_START_CAPTURE, 12'd0, 32'd0);
      send_event(MODE_START_CAPTURE, 12'd0, 32'd0);
      send_event(MODE_SAMPLE, 12'hFFF, 32'd5);
      send_event(MODE_SAMPLE, 12'd0, 32'd6);
      send_event(MODE_START_CALIB, 12'd0, 32'd7);
      send_event(MODE_STOP_CAPTURE, 12'd0, 32'd8);
      send_event(MODE_STOP_CAPTURE, 12'd0, 32'd8);
      clock_ms = 32'hFFFF_FFF0;
      calibration_run(4, 4, 20, 12'd0, 12'd50);
      send_event(MODE_START_CALIB, 12'd0, clock_ms);
      send_event(MODE_START_CALIB, 12'd0, clock_ms);
      send_event(MODE_CANCEL_CALIB, 12'd0, clock_ms);
      send_event(MODE_START_CAPTURE, 12'd0, clock_ms);
      send_event(MODE_SAMPLE, 12'd0, clock_ms);
      send_event(MODE_SAMPLE, 12'hFFF, clock_ms);
      send_event(MODE_SAMPLE, 12'd2000, clock_ms);
      send_event(MODE_STOP_CAPTURE, 12'd0, clock_ms);

      send_idle_pct = 8; recv_idle_pct = 53;
      write_reg(REG_REST_PHASE, 16'd1);
      write_reg(REG_CONTRACT_PHASE, 16'd1);
      write_reg(REG_MIN_RANGE, 16'd0);
      random_phase(170);
      send_idle_pct = 53; recv_idle_pct = 8;
      write_reg(REG_REST_PHASE, 16'hFFFF);
      write_reg(REG_CONTRACT_PHASE, 16'hFFFF);
      write_reg(REG_MIN_RANGE, 16'd4095);
      random_phase(50);
      send_event(MODE_START_CALIB, 12'd0, 32'd0);
      send_event(MODE_SAMPLE, 12'hFFF, 32'h0000_FFFF);
      send_event(MODE_SAMPLE, 12'hFFF, 32'h0001_FFFE);
      send_idle_pct = 0; recv_idle_pct = 0;
      write_reg(REG_REST_PHASE, 16'd60);
      write_reg(REG_CONTRACT_PHASE, 16'd60);
      write_reg(REG_MIN_RANGE, 16'd200);
      random_phase(175);

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (errors == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule
